// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ASSERT_SYNC(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_SYNC(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ===== hw/rtl/i2r_pkg.sv =====
package i2r_pkg;

  // Input value and working remainder width.
  localparam int unsigned ValueW = 12;
  localparam int unsigned CharW  = 8;
  localparam int unsigned StatW  = 2;
  localparam int unsigned WeightW = 10;
  localparam int unsigned PcW    = 5;

  localparam logic [ValueW-1:0] MaxValid = ValueW'(3999);

  // Result status codes.
  localparam logic [StatW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatW-1:0] STATUS_ZERO  = 2'd1;
  localparam logic [StatW-1:0] STATUS_RANGE = 2'd2;

  // ASCII letters of the numerals.
  localparam logic [CharW-1:0] CH_M = 8'h4D;
  localparam logic [CharW-1:0] CH_D = 8'h44;
  localparam logic [CharW-1:0] CH_C = 8'h43;
  localparam logic [CharW-1:0] CH_L = 8'h4C;
  localparam logic [CharW-1:0] CH_X = 8'h58;
  localparam logic [CharW-1:0] CH_V = 8'h56;
  localparam logic [CharW-1:0] CH_I = 8'h49;
  localparam logic [CharW-1:0] CH_NONE = 8'h00;

  // Address of the final microcode word (the "I" step).
  localparam logic [PcW-1:0] LastAddr = 5'd18;

  // Microcode operations.
  typedef enum logic {
    OP_SUB,   // if rest >= weight: emit chr, subtract, go to hit; else go to miss
    OP_CHAR   // emit chr unconditionally, go to hit
  } ucode_op_t;

  typedef struct packed {
    ucode_op_t          op;
    logic [WeightW-1:0] weight;
    logic [CharW-1:0]   chr;
    logic               pair;
    logic [PcW-1:0]     hit;
    logic [PcW-1:0]     miss;
  } ucode_word_t;

endpackage

// ===== hw/rtl/i2r_ucode_rom.sv =====
module i2r_ucode_rom (
  input  logic [i2r_pkg::PcW-1:0] pc,
  output i2r_pkg::ucode_word_t    word
);
  import i2r_pkg::*;

  // Greedy conversion program. Each symbol is one conditional subtract step,
  // and two-letter symbols add one step that emits the second letter.
  always_comb begin
    unique case (pc)
      5'd0:  word = '{OP_SUB,  10'd1000, CH_M, 1'b0, 5'd0,  5'd1};
      5'd1:  word = '{OP_SUB,  10'd900,  CH_C, 1'b1, 5'd2,  5'd3};
      5'd2:  word = '{OP_CHAR, 10'd0,    CH_M, 1'b0, 5'd1,  5'd1};
      5'd3:  word = '{OP_SUB,  10'd500,  CH_D, 1'b0, 5'd3,  5'd4};
      5'd4:  word = '{OP_SUB,  10'd400,  CH_C, 1'b1, 5'd5,  5'd6};
      5'd5:  word = '{OP_CHAR, 10'd0,    CH_D, 1'b0, 5'd4,  5'd4};
      5'd6:  word = '{OP_SUB,  10'd100,  CH_C, 1'b0, 5'd6,  5'd7};
      5'd7:  word = '{OP_SUB,  10'd90,   CH_X, 1'b1, 5'd8,  5'd9};
      5'd8:  word = '{OP_CHAR, 10'd0,    CH_C, 1'b0, 5'd7,  5'd7};
      5'd9:  word = '{OP_SUB,  10'd50,   CH_L, 1'b0, 5'd9,  5'd10};
      5'd10: word = '{OP_SUB,  10'd40,   CH_X, 1'b1, 5'd11, 5'd12};
      5'd11: word = '{OP_CHAR, 10'd0,    CH_L, 1'b0, 5'd10, 5'd10};
      5'd12: word = '{OP_SUB,  10'd10,   CH_X, 1'b0, 5'd12, 5'd13};
      5'd13: word = '{OP_SUB,  10'd9,    CH_I, 1'b1, 5'd14, 5'd15};
      5'd14: word = '{OP_CHAR, 10'd0,    CH_X, 1'b0, 5'd13, 5'd13};
      5'd15: word = '{OP_SUB,  10'd5,    CH_V, 1'b0, 5'd15, 5'd16};
      5'd16: word = '{OP_SUB,  10'd4,    CH_I, 1'b1, 5'd17, 5'd18};
      5'd17: word = '{OP_CHAR, 10'd0,    CH_V, 1'b0, 5'd16, 5'd16};
      5'd18: word = '{OP_SUB,  10'd1,    CH_I, 1'b0, 5'd18, 5'd18};
      // Unused addresses fall back to the final step.
      default: word = '{OP_SUB, 10'd1,   CH_I, 1'b0, LastAddr, LastAddr};
    endcase
  end

endmodule

// ===== hw/rtl/integer_to_roman_numeral.sv =====
// Integer to Roman numeral converter. Each request on the input stream carries a
// 12-bit value; the block answers with its Roman numeral, one ASCII letter per
// output request, tlast marking the final letter. Zero or a value above 3999
// gives one request with letter 0, an error code in tuser and tlast set. The
// conversion is a 19-word microcode program stepped once per cycle, except that
// a step that emits a letter waits while the output register is full: each step
// either emits one letter or skips a symbol that no longer fits. A numeral has
// up to 15 letters, and a value skips up to 12 symbols. The next value is
// accepted once the last letter is in the output register.
module integer_to_roman_numeral (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] value, [15:12] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] numeral_char
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);
  import i2r_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ERR
  } state_t;

  state_t              state_r, state_nxt;
  logic [PcW-1:0]      pc_r, pc_nxt;
  logic [ValueW-1:0]   rest_r, rest_nxt;
  logic [StatW-1:0]    err_r, err_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CharW-1:0]    out_char_r, out_char_nxt;
  logic [StatW-1:0]    out_stat_r, out_stat_nxt;
  logic                out_last_r, out_last_nxt;

  ucode_word_t         word;
  logic [ValueW-1:0]   weight_ext;
  logic [ValueW-1:0]   diff;
  logic                fits;
  logic                slot_free;
  logic                emit_last;
  logic [ValueW-1:0]   in_value;

  // Control store.
  i2r_ucode_rom u_rom (
    .pc   (pc_r),
    .word (word)
  );

  // Datapath: one compare and subtract against the current weight.
  assign in_value   = in_tdata[ValueW-1:0];
  assign weight_ext = {{(ValueW-WeightW){1'b0}}, word.weight};
  assign diff       = rest_r - weight_ext;
  assign fits       = (rest_r >= weight_ext);
  assign slot_free  = !out_valid_r || out_tready;
  assign emit_last  = (word.op == OP_SUB) ? ((diff == '0) && !word.pair)
                                          : (rest_r == '0);

  // Sequencer next state.
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    rest_nxt      = rest_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_stat_nxt  = out_stat_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          rest_nxt = in_value;
          pc_nxt   = '0;
          if (in_value == '0) begin
            err_nxt   = STATUS_ZERO;
            state_nxt = ST_ERR;
          end else if (in_value > MaxValid) begin
            err_nxt   = STATUS_RANGE;
            state_nxt = ST_ERR;
          end else begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_NONE;
          out_stat_nxt  = err_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_RUN: begin
        if ((word.op == OP_SUB) && !fits) begin
          pc_nxt = word.miss;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = word.chr;
          out_stat_nxt  = STATUS_OK;
          out_last_nxt  = emit_last;
          pc_nxt        = word.hit;
          if (word.op == OP_SUB) begin
            rest_nxt = diff;
          end
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pc_r       <= pc_nxt;
    rest_r     <= rest_nxt;
    err_r      <= err_nxt;
    out_char_r <= out_char_nxt;
    out_stat_r <= out_stat_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

  // An error status always closes its run.
  `ASSERT_SYNC(a_err_is_last, clk, rst_n, (out_valid_r && (out_stat_r != STATUS_OK)) |-> out_last_r)
  // A subtract step is only reached while something remains to convert.
  `ASSERT_NEVER(a_sub_rest_zero, clk, rst_n, (state_r == ST_RUN) && (word.op == OP_SUB) && (rest_r == '0))
  // The program counter stays inside the program.
  `ASSERT_NEVER(a_pc_range, clk, rst_n, (state_r == ST_RUN) && (pc_r > LastAddr))
  // An accepted request leaves the idle state.
  `ASSERT_SYNC(a_accept_busy, clk, rst_n, (in_tvalid && in_tready) |=> (state_r != ST_IDLE))

endmodule
